/* src/pms_pkg.sv */
// ----------------------------------------------------------------------------
// Merge sorter package
// Shared constants for the pipelined 16-byte merge sorter: default element
// count and width, channel word width and the number of merge stages.
// ----------------------------------------------------------------------------
package pms_pkg;

   // Default vector geometry: 16 elements of 8 bits.
   localparam int NUM_ELEMENTS_DEF = 16;
   localparam int ELEMENT_BITS_DEF = 8;

   // Each channel word is 64 bits; two words carry one vector.
   localparam int WORD_BITS = 64;
   localparam int PACK_BITS = 2 * WORD_BITS;

   // Pair sort, then merges into runs of 4, 8 and 16.
   localparam int STAGE_COUNT = 4;

endpackage

/* src/pms_if.sv */
// ----------------------------------------------------------------------------
// Merge sorter channels
// Valid/ready interfaces for the request channel (unsorted vector) and the
// result channel (sorted vector).
// ----------------------------------------------------------------------------
interface pms_req_if;
   import pms_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] data_low;
   logic [WORD_BITS-1:0] data_high;

   modport source (output valid, output data_low, output data_high, input ready);
   modport sink   (input valid, input data_low, input data_high, output ready);
endinterface

interface pms_rsp_if;
   import pms_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] sorted_low;
   logic [WORD_BITS-1:0] sorted_high;

   modport source (output valid, output sorted_low, output sorted_high, input ready);
   modport sink   (input valid, input sorted_low, input sorted_high, output ready);
endinterface

/* src/pipelined_merge_sorter_16_bytes_top.sv */
// ----------------------------------------------------------------------------
// Pipelined merge sorter, 16 bytes
// Four-stage merge-sort pipeline over vectors of unsigned elements.
// ----------------------------------------------------------------------------
// Usage.
// A request carries one vector of NUM_ELEMENTS unsigned elements packed back
// to back in data_low and data_high, element 0 in the low bits of data_low.
// Each accepted request produces exactly one result on the rsp channel.
// The pipeline moves one place forward only when a request is accepted, so
// the result for a request is the sorted form of the vector accepted four
// requests earlier; the first four results after reset are all zero.
// The result is sorted ascending, smallest element in the low bits of
// sorted_low; output bits not covered by an element are zero.
// The result of a request is loaded into the output register when the request
// that pushes it out is accepted, and that request is the fourth one after it.
// Throughput: one request per cycle. The output register frees up in the same
// cycle in which its result is taken, so req_chan.ready stays high while the
// receiver keeps up; each stage is one compare-and-select merge network.
// When the receiver stalls with a result waiting, req_chan.ready drops and
// all stages hold. Reset (synchronous) clears every stage to zero and
// empties the output register.
// ----------------------------------------------------------------------------
module pipelined_merge_sorter_16_bytes_top #(
   parameter int NUM_ELEMENTS = pms_pkg::NUM_ELEMENTS_DEF,
   parameter int ELEMENT_BITS = pms_pkg::ELEMENT_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   pms_req_if.sink   req_chan,
   pms_rsp_if.source rsp_chan
);
   import pms_pkg::*;

   // Elements of all stage boundaries: index 0 is the unpacked request,
   // index STAGE_COUNT the fully sorted vector.
   logic [ELEMENT_BITS-1:0] chain_w [STAGE_COUNT+1][NUM_ELEMENTS];

   logic [PACK_BITS-1:0] req_pack_w;
   logic [PACK_BITS-1:0] rsp_pack_w;
   logic                 req_ready_w;
   logic                 accept_w;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [WORD_BITS-1:0] sorted_low_ff;
   logic [WORD_BITS-1:0] sorted_high_ff;

   // A new request is taken whenever the output register is empty or its
   // result is being taken in this same cycle.
   assign req_ready_w    = !rsp_valid_ff || rsp_chan.ready;
   assign accept_w       = req_chan.valid && req_ready_w;
   assign req_chan.ready = req_ready_w;

   // Unpack the request. Element bits that fall beyond the two words read
   // as zero.
   assign req_pack_w = {req_chan.data_high, req_chan.data_low};

   for (genvar i = 0; i < NUM_ELEMENTS; i++) begin : g_unpack
      for (genvar b = 0; b < ELEMENT_BITS; b++) begin : g_bit
         localparam int POS = i * ELEMENT_BITS + b;
         if (POS < PACK_BITS) begin : g_in
            assign chain_w[0][i][b] = req_pack_w[POS];
         end else begin : g_out
            assign chain_w[0][i][b] = 1'b0;
         end
      end
   end

   // The four merge stages: pairs, runs of four, runs of eight, full vector.
   for (genvar s = 0; s < STAGE_COUNT; s++) begin : g_stage
      pms_merge_stage #(
         .NUM_ELEMENTS (NUM_ELEMENTS),
         .ELEMENT_BITS (ELEMENT_BITS),
         .HALF         (1 << s)
      ) u_merge (
         .clock    (clock),
         .reset    (reset),
         .advance  (accept_w),
         .src_data (chain_w[s]),
         .dst_data (chain_w[s+1])
      );
   end

   // Pack the last stage as it stands before the pipe advances. Bits not
   // covered by any element are zero.
   for (genvar p = 0; p < PACK_BITS; p++) begin : g_pack
      localparam int ELEM = p / ELEMENT_BITS;
      localparam int BITN = p % ELEMENT_BITS;
      if (ELEM < NUM_ELEMENTS) begin : g_in
         assign rsp_pack_w[p] = chain_w[STAGE_COUNT][ELEM][BITN];
      end else begin : g_out
         assign rsp_pack_w[p] = 1'b0;
      end
   end

   // Output register: loads on every accepted request, empties when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept_w) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_w) begin
         sorted_low_ff  <= rsp_pack_w[WORD_BITS-1:0];
         sorted_high_ff <= rsp_pack_w[PACK_BITS-1:WORD_BITS];
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.sorted_low  = sorted_low_ff;
   assign rsp_chan.sorted_high = sorted_high_ff;

   // Every accepted request leaves a result waiting in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept_w |=> rsp_chan.valid)
      else $error("accepted request produced no result");

   // A waiting result that is not taken blocks new requests.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request accepted while a result is stalled");

   // The sorted stage only moves when a request is accepted.
   assert property (@(posedge clock) disable iff (reset)
      !accept_w |=> $stable(rsp_pack_w))
      else $error("last stage changed without an accepted request");

   // With enough stages for the vector length, the last stage is always sorted.
   if (NUM_ELEMENTS <= (1 << STAGE_COUNT)) begin : g_order_check
      logic [NUM_ELEMENTS-2:0] ordered_w;
      for (genvar k = 0; k < NUM_ELEMENTS - 1; k++) begin : g_pair
         assign ordered_w[k] = chain_w[STAGE_COUNT][k] <= chain_w[STAGE_COUNT][k+1];
      end

      assert property (@(posedge clock) disable iff (reset)
         &ordered_w)
         else $error("last stage is not in ascending order");
   end

endmodule

/* src/pms_merge_stage.sv */
// ----------------------------------------------------------------------------
// Merge stage
// Merges adjacent sorted runs of HALF elements into runs of 2*HALF with a
// rank-and-select network, and registers the result when the pipe advances.
// ----------------------------------------------------------------------------
module pms_merge_stage #(
   parameter int NUM_ELEMENTS = pms_pkg::NUM_ELEMENTS_DEF,
   parameter int ELEMENT_BITS = pms_pkg::ELEMENT_BITS_DEF,
   parameter int HALF         = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [ELEMENT_BITS-1:0] src_data [NUM_ELEMENTS],
   output logic [ELEMENT_BITS-1:0] dst_data [NUM_ELEMENTS]
);
   import pms_pkg::*;

   localparam int WIDTH = 2 * HALF;
   localparam int IDX_W = $clog2(NUM_ELEMENTS);

   logic [IDX_W-1:0]        rank_w  [NUM_ELEMENTS];
   logic [ELEMENT_BITS-1:0] stage_in [NUM_ELEMENTS];
   logic [ELEMENT_BITS-1:0] stage_ff [NUM_ELEMENTS];

   // Each element's place in its merged run is its place in its own run plus
   // the number of elements of the other run that go ahead of it. Ties go to
   // the left run, which keeps the merge stable.
   for (genvar i = 0; i < NUM_ELEMENTS; i++) begin : g_rank
      localparam int FIRST = (i / WIDTH) * WIDTH;
      localparam int MID   = (FIRST + HALF > NUM_ELEMENTS) ? NUM_ELEMENTS : FIRST + HALF;
      localparam int LAST  = (FIRST + WIDTH > NUM_ELEMENTS) ? NUM_ELEMENTS : FIRST + WIDTH;

      logic [IDX_W-1:0] rank;

      if (i < MID) begin : g_left
         always_comb begin
            rank = IDX_W'(i);
            for (int j = MID; j < LAST; j++) begin
               if (src_data[j] < src_data[i]) begin
                  rank = rank + IDX_W'(1);
               end
            end
         end
      end else begin : g_right
         always_comb begin
            rank = IDX_W'(i - MID + FIRST);
            for (int j = FIRST; j < MID; j++) begin
               if (src_data[j] <= src_data[i]) begin
                  rank = rank + IDX_W'(1);
               end
            end
         end
      end

      assign rank_w[i] = rank;
   end

   // Ranks within a run are distinct, so each slot picks exactly one element.
   for (genvar k = 0; k < NUM_ELEMENTS; k++) begin : g_select
      localparam int FIRST = (k / WIDTH) * WIDTH;
      localparam int LAST  = (FIRST + WIDTH > NUM_ELEMENTS) ? NUM_ELEMENTS : FIRST + WIDTH;

      logic [ELEMENT_BITS-1:0] pick;

      always_comb begin
         pick = '0;
         for (int i = FIRST; i < LAST; i++) begin
            if (rank_w[i] == IDX_W'(k)) begin
               pick = pick | src_data[i];
            end
         end
      end

      assign stage_in[k] = pick;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_ELEMENTS; k++) begin
            stage_ff[k] <= '0;
         end
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign dst_data = stage_ff;

endmodule
